/* rtl/txy_pkg.sv */
`default_nettype none

package txy_pkg;

    localparam int MAX_DIM     = 16;
    localparam int COORD_SPAN  = 16;
    localparam int COORD_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // largest usable ring size: bounded by the coordinate span
    localparam int SIZE_LIM_I  = (MAX_DIM > COORD_SPAN) ? COORD_SPAN : MAX_DIM;
    localparam logic [SIZE_W-1:0] SIZE_LIM = SIZE_W'(SIZE_LIM_I);

    localparam logic [SIZE_W-1:0] SIZE_X_RST = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] SIZE_Y_RST = SIZE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X   = 2'd0,
        REG_SIZE_Y   = 2'd1,
        REG_BOTH_DIR = 2'd2
    } cfg_reg_t;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;

    typedef struct packed {
        coord_t src_x;
        coord_t src_y;
        coord_t dst_x;
        coord_t dst_y;
    } req_t;

    typedef struct packed {
        size_t size_x;
        size_t size_y;
        logic  both_dir;
    } cfg_t;

    typedef struct packed {
        logic move_x;
        logic move_y;
        logic arrived;
        logic oor;
    } status_t;

    typedef struct packed {
        coord_t  src_x;
        coord_t  src_y;
        coord_t  cur;
        coord_t  dst;
        size_t   n;
        logic    both_dir;
        status_t st;
    } sel_t;

    typedef struct packed {
        coord_t  src_x;
        coord_t  src_y;
        coord_t  cur;
        size_t   n;
        size_t   fwd;
        logic    both_dir;
        status_t st;
    } dist_t;

    typedef struct packed {
        coord_t next_x;
        coord_t next_y;
        logic   arrived;
        logic   out_of_range;
    } rsp_t;

    function automatic size_t eff_size(input size_t s);
        return (s > SIZE_LIM) ? SIZE_LIM : s;
    endfunction

endpackage

`default_nettype wire

/* rtl/txy_in_if.sv */
`default_nettype none

interface txy_in_if import txy_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t src_x;
    coord_t src_y;
    coord_t dst_x;
    coord_t dst_y;

    modport source (output valid, output src_x, output src_y, output dst_x, output dst_y,
                    input ready);
    modport sink   (input valid, input src_x, input src_y, input dst_x, input dst_y,
                    output ready);
endinterface

`default_nettype wire

/* rtl/txy_out_if.sv */
`default_nettype none

interface txy_out_if import txy_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t next_x;
    coord_t next_y;
    logic   arrived;
    logic   out_of_range;

    modport source (output valid, output next_x, output next_y, output arrived,
                    output out_of_range, input ready);
    modport sink   (input valid, input next_x, input next_y, input arrived,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

/* rtl/torus_xy_next_hop.sv */
// next-hop unit for x-then-y routing on a wrapped grid
// each accepted item is registered in every stage below before its result shows on rsp
// throughput: one item per cycle while rsp is ready, through three register stages
// (range check and dimension select, ring distance, step and result)
// reset: all stage valid bits cleared, size_x = 4, size_y = 1, both_directions = 0
`default_nettype none

module torus_xy_next_hop import txy_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    txy_in_if.sink                     req,
    txy_out_if.source                  rsp
);

    size_t size_x_reg;
    size_t size_y_reg;
    logic  both_dir_reg;
    cfg_t  cfg;
    req_t  req_data;

    logic  s1_valid;
    logic  s1_ready;
    sel_t  s1_data;
    logic  s2_valid;
    logic  s2_ready;
    dist_t s2_data;
    rsp_t  rsp_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg   <= SIZE_X_RST;
            size_y_reg   <= SIZE_Y_RST;
            both_dir_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SIZE_X:   size_x_reg   <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   size_y_reg   <= cfg_data[SIZE_W-1:0];
                REG_BOTH_DIR: both_dir_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg.size_x   = size_x_reg;
    assign cfg.size_y   = size_y_reg;
    assign cfg.both_dir = both_dir_reg;

    assign req_data.src_x = req.src_x;
    assign req_data.src_y = req.src_y;
    assign req_data.dst_x = req.dst_x;
    assign req_data.dst_y = req.dst_y;

    txy_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req_data),
        .cfg       (cfg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    txy_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    txy_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data)
    );

    assign rsp.next_x       = rsp_data.next_x;
    assign rsp.next_y       = rsp_data.next_y;
    assign rsp.arrived      = rsp_data.arrived;
    assign rsp.out_of_range = rsp_data.out_of_range;

endmodule

`default_nettype wire

/* rtl/txy_check.sv */
`default_nettype none

module txy_check import txy_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    input  wire cfg_t cfg,
    output logic      out_valid,
    input  wire logic out_ready,
    output sel_t      out_data
);

    logic  valid_reg;
    sel_t  data_reg;
    sel_t  data_next;
    size_t nx;
    size_t ny;
    logic  oor;
    logic  x_diff;
    logic  y_diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        nx     = eff_size(cfg.size_x);
        ny     = eff_size(cfg.size_y);
        oor    = ({1'b0, in_data.src_x} >= nx) || ({1'b0, in_data.dst_x} >= nx)
              || ({1'b0, in_data.src_y} >= ny) || ({1'b0, in_data.dst_y} >= ny);
        x_diff = in_data.src_x != in_data.dst_x;
        y_diff = in_data.src_y != in_data.dst_y;

        data_next.src_x       = in_data.src_x;
        data_next.src_y       = in_data.src_y;
        data_next.both_dir    = cfg.both_dir;
        data_next.st.oor      = oor;
        data_next.st.move_x   = !oor && x_diff;
        data_next.st.move_y   = !oor && !x_diff && y_diff;
        data_next.st.arrived  = !oor && !x_diff && !y_diff;
        // x is corrected first, y only once x matches
        if (x_diff)
        begin
            data_next.cur = in_data.src_x;
            data_next.dst = in_data.dst_x;
            data_next.n   = nx;
        end
        else
        begin
            data_next.cur = in_data.src_y;
            data_next.dst = in_data.dst_y;
            data_next.n   = ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/txy_dist.sv */
`default_nettype none

module txy_dist import txy_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sel_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output dist_t     out_data
);

    logic  valid_reg;
    dist_t data_reg;
    dist_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.src_x    = in_data.src_x;
        data_next.src_y    = in_data.src_y;
        data_next.cur      = in_data.cur;
        data_next.n        = in_data.n;
        data_next.both_dir = in_data.both_dir;
        data_next.st       = in_data.st;
        // forward distance around the ring
        if (in_data.dst >= in_data.cur)
        begin
            data_next.fwd = {1'b0, in_data.dst} - {1'b0, in_data.cur};
        end
        else
        begin
            data_next.fwd = {1'b0, in_data.dst} + in_data.n - {1'b0, in_data.cur};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/txy_step.sv */
`default_nettype none

module txy_step import txy_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire dist_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output rsp_t       out_data
);

    logic   valid_reg;
    rsp_t   data_reg;
    rsp_t   data_next;
    size_t  bwd;
    size_t  cur_inc;
    logic   go_back;
    coord_t step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        bwd     = in_data.n - in_data.fwd;
        go_back = in_data.both_dir && (bwd < in_data.fwd);
        cur_inc = {1'b0, in_data.cur} + size_t'(1);
        if (go_back)
        begin
            if (in_data.cur == '0)
            begin
                step = coord_t'(in_data.n - size_t'(1));
            end
            else
            begin
                step = in_data.cur - coord_t'(1);
            end
        end
        else
        begin
            // ties go forward
            step = (cur_inc >= in_data.n) ? '0 : coord_t'(cur_inc);
        end

        data_next.next_x       = in_data.st.move_x ? step : in_data.src_x;
        data_next.next_y       = in_data.st.move_y ? step : in_data.src_y;
        data_next.arrived      = in_data.st.arrived;
        data_next.out_of_range = in_data.st.oor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
